// ===== src/sidrr_pkg.sv =====
// Shared types and constants for the dynamic sequence range-count block.
package sidrr_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Field widths of the stream beats
    localparam int KIND_W    = 2;
    localparam int POS_W     = 11;
    localparam int RIGHT_W   = 10;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int LENGTH_W  = 11;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_COUNT  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_CNT
    } t_state;

    // Broadcast operation strobes to every cell
    typedef struct packed {
        logic ins;
        logic del;
        logic cnt;
    } t_cell_op;

endpackage

// ===== src/sidrr_cell.sv =====
// One storage cell of the sequence chain: shifts with its neighbors, flags a count hit.
module sidrr_cell #(
    parameter int IDX        = 0,
    parameter int CW         = 11,
    parameter int VALUE_BITS = sidrr_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  sidrr_pkg::t_cell_op   i_op,
    input  logic [CW-1:0]         i_pos,
    input  logic [CW-1:0]         i_left,
    input  logic [CW-1:0]         i_right,
    input  logic [VALUE_BITS-1:0] i_new,
    input  logic [VALUE_BITS-1:0] i_prev,
    input  logic [VALUE_BITS-1:0] i_next,
    output logic [VALUE_BITS-1:0] o_val,
    output logic                  o_hit
);
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [VALUE_BITS-1:0] r_val;
    logic                  r_hit;

    always_ff @(posedge i_clk) begin
        if (i_op.ins) begin
            if (MY_IDX == i_pos) begin
                r_val <= i_new;
            end else if (MY_IDX > i_pos) begin
                r_val <= i_prev;
            end
        end else if (i_op.del) begin
            if (MY_IDX >= i_pos) begin
                r_val <= i_next;
            end
        end
    end

    // Signed compare against the broadcast threshold
    always_ff @(posedge i_clk) begin
        r_hit <= i_op.cnt && (MY_IDX >= i_left) && (MY_IDX <= i_right)
                 && ($signed(r_val) <= $signed(i_new));
    end

    assign o_val = r_val;
    assign o_hit = r_hit;

endmodule

// ===== src/sidrr_tree.sv =====
// Pipelined binary adder tree that counts the hit flags of all cells.
module sidrr_tree #(
    parameter int N = sidrr_pkg::CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [N-1:0]              i_hit,
    output logic                      o_valid,
    output logic [$clog2(N+1)-1:0]    o_sum
);
    localparam int L     = $clog2(N);
    localparam int SUM_W = $clog2(N + 1);
    localparam int LEAVES = 2 ** L;

    logic [SUM_W-1:0] w_leaf [LEAVES];
    logic [SUM_W-1:0] r_node [1:L][LEAVES];
    logic [L-1:0]     r_vld;

    // Pad to a power of two with zero leaves
    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
        if (j < N) begin : g_real
            assign w_leaf[j] = SUM_W'(i_hit[j]);
        end else begin : g_pad
            assign w_leaf[j] = '0;
        end
    end

    for (genvar k = 1; k <= L; k++) begin : g_lvl
        if (k == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                for (int j = 0; j < (2 ** (L - 1)); j++) begin
                    r_node[1][j] <= w_leaf[2*j] + w_leaf[2*j+1];
                end
            end
        end else begin : g_upper
            always_ff @(posedge i_clk) begin
                for (int j = 0; j < (2 ** (L - k)); j++) begin
                    r_node[k][j] <= r_node[k-1][2*j] + r_node[k-1][2*j+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld << 1) | L'(i_valid);
        end
    end

    assign o_valid = r_vld[L-1];
    assign o_sum   = r_node[L][0];

endmodule

// ===== src/sequence_insert_delete_range_rank_core.sv =====
// Top level: ordered sequence store with insert, delete and range count-at-or-below.
//
// Usage notes
//  - Slave stream (i_s_*): one beat is one request. tuser carries the kind
//    (insert, delete, count); tdata carries position, right end and value.
//  - Master stream (o_m_*): exactly one beat per request with count, status
//    and the length after the request, in request order.
//  - Storage is a chain of CAPACITY cells. Insert and delete move every cell
//    at or above the position one step toward or away from its neighbor, all in the same clock.
//  - Timing: insert, delete and every error or empty-range count give their
//    beat in the cycle after acceptance. A counted range passes through the
//    per-cell compare register, then each level of the registered adder
//    tree, then the output register.
//  - Throughput: insert and delete run at one beat per cycle while the sink
//    takes results; a counted range holds the input until its sum returns.
//  - The output register frees the input side: a new beat is taken in the
//    same cycle the previous result is taken.
//  - Reset (synchronous, active low) empties the sequence; cell contents are
//    not cleared, since only entries below the length are ever read.
//  - A stalled sink holds the result and backpressures the input.
module sequence_insert_delete_range_rank_core #(
    parameter int CAPACITY   = sidrr_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sidrr_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [10:0] position, [20:11] right_end, [52:21] value, [55:53] zero
    input  logic [sidrr_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] kind
    input  logic [sidrr_pkg::KIND_W-1:0]    i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [10:0] count, [12:11] status, [23:13] length
    output logic [sidrr_pkg::M_TDATA_W-1:0] o_m_tdata
);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CW    = (LEN_W > sidrr_pkg::POS_W) ? LEN_W : sidrr_pkg::POS_W;
    localparam int SUM_W = $clog2(CAPACITY + 1);

    // Input beat fields
    sidrr_pkg::t_kind                 s_kind;
    logic [sidrr_pkg::POS_W-1:0]      s_pos;
    logic [sidrr_pkg::RIGHT_W-1:0]    s_right;
    logic [sidrr_pkg::VALUE_W-1:0]    s_value;
    logic [VALUE_BITS-1:0]            s_key;

    assign s_kind  = sidrr_pkg::t_kind'(i_s_tuser);
    assign s_pos   = i_s_tdata[10:0];
    assign s_right = i_s_tdata[20:11];
    assign s_value = i_s_tdata[52:21];

    if (VALUE_BITS <= sidrr_pkg::VALUE_W) begin : g_key_trunc
        assign s_key = s_value[VALUE_BITS-1:0];
    end else begin : g_key_ext
        assign s_key = {{(VALUE_BITS - sidrr_pkg::VALUE_W){s_value[sidrr_pkg::VALUE_W-1]}},
                        s_value};
    end

    // Control state
    sidrr_pkg::t_state r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_cnt_go;
    logic              r_out_valid, n_out_valid;
    logic [sidrr_pkg::COUNT_W-1:0]  r_o_count, n_o_count;
    sidrr_pkg::t_status             r_o_status, n_o_status;
    logic [sidrr_pkg::LENGTH_W-1:0] r_o_len, n_o_len;

    logic                  accept;
    logic                  load;
    sidrr_pkg::t_cell_op   op;
    logic [CW-1:0]         pos_c, right_c, len_c, pos_eff;
    logic                  tree_valid;
    logic [SUM_W-1:0]      tree_sum;
    logic [CAPACITY-1:0]   hits;

    assign o_s_tready = (r_state == sidrr_pkg::S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;

    assign pos_c   = CW'(s_pos);
    assign right_c = CW'(s_right);
    assign len_c   = CW'(r_len);
    assign pos_eff = (pos_c > len_c) ? len_c : pos_c;   // insert past end appends

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        op          = '0;
        load        = 1'b0;
        n_o_count   = '0;
        n_o_status  = sidrr_pkg::ST_OK;
        n_o_len     = sidrr_pkg::LENGTH_W'(r_len);
        unique case (r_state)
            sidrr_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (s_kind)
                        sidrr_pkg::KIND_INSERT: begin
                            load = 1'b1;
                            if (r_len == LEN_W'(CAPACITY)) begin
                                n_o_status = sidrr_pkg::ST_FULL;
                            end else begin
                                op.ins  = 1'b1;
                                n_len   = r_len + 1'b1;
                                n_o_len = sidrr_pkg::LENGTH_W'(n_len);
                            end
                        end
                        sidrr_pkg::KIND_DELETE: begin
                            load = 1'b1;
                            if (pos_c >= len_c) begin
                                n_o_status = sidrr_pkg::ST_RANGE;
                            end else begin
                                op.del  = 1'b1;
                                n_len   = r_len - 1'b1;
                                n_o_len = sidrr_pkg::LENGTH_W'(n_len);
                            end
                        end
                        sidrr_pkg::KIND_COUNT: begin
                            // Right-end check wins over an empty range
                            if (right_c >= len_c) begin
                                load       = 1'b1;
                                n_o_status = sidrr_pkg::ST_RANGE;
                            end else if (pos_c > right_c) begin
                                load = 1'b1;
                            end else begin
                                op.cnt  = 1'b1;
                                n_state = sidrr_pkg::S_CNT;
                            end
                        end
                        default: begin
                            load       = 1'b1;
                            n_o_status = sidrr_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            sidrr_pkg::S_CNT: begin
                if (tree_valid) begin
                    load      = 1'b1;
                    n_o_count = sidrr_pkg::COUNT_W'(tree_sum);
                    n_state   = sidrr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sidrr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sidrr_pkg::S_IDLE;
            r_len       <= '0;
            r_cnt_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cnt_go    <= op.cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_count  <= n_o_count;
            r_o_status <= n_o_status;
            r_o_len    <= n_o_len;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_o_len, r_o_status, r_o_count};

    // Cell chain: each inner cell sees its left and right neighbor; the first takes the key, the last its own value
    logic [VALUE_BITS-1:0] vals [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_BITS-1:0] w_prev, w_next;
        if (i == 0) begin : g_first
            assign w_prev = s_key;
        end else begin : g_mid_prev
            assign w_prev = vals[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_next = vals[i];
        end else begin : g_mid_next
            assign w_next = vals[i+1];
        end

        sidrr_cell #(
            .IDX        (i),
            .CW         (CW),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (op),
            .i_pos   ((op.ins) ? pos_eff : pos_c),
            .i_left  (pos_c),
            .i_right (right_c),
            .i_new   (s_key),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_val   (vals[i]),
            .o_hit   (hits[i])
        );
    end

    sidrr_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_cnt_go),
        .i_hit   (hits),
        .o_valid (tree_valid),
        .o_sum   (tree_sum)
    );

endmodule

// ===== src/sidrr_chk.sv =====
// Port-level checker for the sequence range-count block, bound to the top level.
module sidrr_chk #(
    parameter int CAPACITY = sidrr_pkg::CAPACITY_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [sidrr_pkg::M_TDATA_W-1:0] o_m_tdata
);
    // Result beat held while the sink stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // Only defined status codes leave the block
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[12:11] == sidrr_pkg::ST_OK)
                    || (o_m_tdata[12:11] == sidrr_pkg::ST_FULL)
                    || (o_m_tdata[12:11] == sidrr_pkg::ST_RANGE))
        else $error("undefined status code");

    // A nonzero count only comes with an ok status
    a_cnt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[10:0] != '0) |-> o_m_tdata[12:11] == sidrr_pkg::ST_OK)
        else $error("nonzero count on error");

    // Reported length never exceeds capacity
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> 32'(o_m_tdata[23:13]) <= 32'(CAPACITY))
        else $error("length above capacity");

    // No result right after a reset cycle
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind sequence_insert_delete_range_rank_core sidrr_chk #(
    .CAPACITY (CAPACITY)
) u_sidrr_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
